// ===== design/esp3_frame_receiver_defines.svh =====
// Assertion macros for the ESP3 frame receiver.
// Needs clk and rst_n in the scope of each use; empty when SYNTHESIS is set.
`ifndef ESP3_FRAME_RECEIVER_DEFINES_SVH
`define ESP3_FRAME_RECEIVER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ESP3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define ESP3_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ESP3_ASSERT_IMP(lbl, ante, cons, msg)
`define ESP3_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/esp3_fr_pkg.sv =====
// Shared types, constants and the CRC-8 step for the ESP3 frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package esp3_fr_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam int unsigned OVERHEAD   = 7;
  localparam int unsigned POS_LEN_HI = 1;
  localparam int unsigned POS_LEN_LO = 2;
  localparam int unsigned POS_OPT    = 3;
  localparam int unsigned HEADER_LEN = 4;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HEADER,
    PH_HCRC,
    PH_BODY,
    PH_DCRC
  } phase_t;

  typedef enum logic [2:0] {
    EV_RESYNC    = 3'd1,
    EV_HDR_CRC   = 3'd2,
    EV_DATA_CRC  = 3'd3,
    EV_GOOD      = 3'd4
  } evt_code_t;

  typedef struct packed {
    logic [31:0] resync;
    logic [31:0] hdr_err;
    logic [31:0] data_err;
    logic [31:0] good;
  } cnt_t;

  typedef struct packed {
    logic      stat_valid;
    evt_code_t stat_code;
    logic      frame_done;
  } evt_t;

  // CRC-8, MSB first, no final xor
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== design/esp3_fr_store.sv =====
// Frame store: single-port-write, single-port-read synchronous RAM.
// Read data is registered and held while rd_en is low. No dependencies.
`timescale 1ns / 1ps

module esp3_fr_store #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/esp3_fr_parser.sv =====
// Byte parser: sync hunt, length check, header and body CRC checks, frame counters.
// Writes every frame byte to the frame store. Depends on esp3_fr_pkg.
`timescale 1ns / 1ps

module esp3_fr_parser import esp3_fr_pkg::*; #(
  parameter int FRAME_BYTES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              byte_acc,
  input  logic [7:0]                        byte_in,
  output logic                              wr_en,
  output logic [$clog2(FRAME_BYTES)-1:0]    wr_addr,
  output logic [7:0]                        wr_data,
  output evt_t                              evt,
  output logic [$clog2(FRAME_BYTES+1)-1:0]  frame_len,
  output cnt_t                              cnt
);

  localparam int CNT_W  = $clog2(FRAME_BYTES + 1);
  localparam int ADDR_W = $clog2(FRAME_BYTES);

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] wp_r, wp_nxt;
  logic [7:0]       len_hi_r, len_hi_nxt;
  logic [7:0]       len_lo_r, len_lo_nxt;
  logic [7:0]       opt_r, opt_nxt;
  logic [CNT_W-1:0] btot_r, btot_nxt;
  logic [CNT_W-1:0] bcnt_r, bcnt_nxt;
  logic [7:0]       hcrc_r, hcrc_nxt;
  logic [7:0]       bcrc_r, bcrc_nxt;
  cnt_t             cnt_r, cnt_nxt;

  logic [16:0]      body_total;
  logic [17:0]      frame_need;
  logic             store;

  assign body_total = 17'({len_hi_r, len_lo_r}) + 17'(opt_r);
  assign frame_need = 18'(body_total) + 18'(OVERHEAD);

  always_comb begin
    phase_nxt  = phase_r;
    wp_nxt     = wp_r;
    len_hi_nxt = len_hi_r;
    len_lo_nxt = len_lo_r;
    opt_nxt    = opt_r;
    btot_nxt   = btot_r;
    bcnt_nxt   = bcnt_r;
    hcrc_nxt   = hcrc_r;
    bcrc_nxt   = bcrc_r;
    cnt_nxt    = cnt_r;
    store      = 1'b0;
    evt        = '{stat_valid: 1'b0, stat_code: EV_RESYNC, frame_done: 1'b0};

    if (byte_acc) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (byte_in == SYNC_BYTE) begin
            store     = 1'b1;
            wp_nxt    = CNT_W'(1);
            hcrc_nxt  = '0;
            phase_nxt = PH_HEADER;
          end
        end
        PH_HEADER: begin
          store    = 1'b1;
          wp_nxt   = wp_r + CNT_W'(1);
          hcrc_nxt = crc8_step(hcrc_r, byte_in);
          if (wp_r == CNT_W'(POS_LEN_HI)) begin
            len_hi_nxt = byte_in;
          end
          if (wp_r == CNT_W'(POS_LEN_LO)) begin
            len_lo_nxt = byte_in;
          end
          if (wp_r == CNT_W'(POS_OPT)) begin
            opt_nxt = byte_in;
          end
          if (wp_r == CNT_W'(HEADER_LEN)) begin
            if (frame_need > 18'(FRAME_BYTES)) begin
              cnt_nxt.resync = cnt_r.resync + 32'd1;
              evt.stat_valid = 1'b1;
              evt.stat_code  = EV_RESYNC;
              phase_nxt      = PH_HUNT;
              wp_nxt         = '0;
            end else begin
              btot_nxt  = body_total[CNT_W-1:0];
              phase_nxt = PH_HCRC;
            end
          end
        end
        PH_HCRC: begin
          store  = 1'b1;
          wp_nxt = wp_r + CNT_W'(1);
          if (byte_in != hcrc_r) begin
            cnt_nxt.hdr_err = cnt_r.hdr_err + 32'd1;
            cnt_nxt.resync  = cnt_r.resync + 32'd1;
            evt.stat_valid  = 1'b1;
            evt.stat_code   = EV_HDR_CRC;
            phase_nxt       = PH_HUNT;
            wp_nxt          = '0;
          end else begin
            bcnt_nxt  = '0;
            bcrc_nxt  = '0;
            phase_nxt = (btot_r == '0) ? PH_DCRC : PH_BODY;
          end
        end
        PH_BODY: begin
          store    = 1'b1;
          wp_nxt   = wp_r + CNT_W'(1);
          bcrc_nxt = crc8_step(bcrc_r, byte_in);
          bcnt_nxt = bcnt_r + CNT_W'(1);
          if (bcnt_nxt >= btot_r) begin
            phase_nxt = PH_DCRC;
          end
        end
        PH_DCRC: begin
          store     = 1'b1;
          phase_nxt = PH_HUNT;
          wp_nxt    = '0;
          if (byte_in != bcrc_r) begin
            cnt_nxt.data_err = cnt_r.data_err + 32'd1;
            evt.stat_valid   = 1'b1;
            evt.stat_code    = EV_DATA_CRC;
          end else begin
            cnt_nxt.good   = cnt_r.good + 32'd1;
            evt.frame_done = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          wp_nxt    = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      wp_r     <= '0;
      len_hi_r <= '0;
      len_lo_r <= '0;
      opt_r    <= '0;
      btot_r   <= '0;
      bcnt_r   <= '0;
      hcrc_r   <= '0;
      bcrc_r   <= '0;
      cnt_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      wp_r     <= wp_nxt;
      len_hi_r <= len_hi_nxt;
      len_lo_r <= len_lo_nxt;
      opt_r    <= opt_nxt;
      btot_r   <= btot_nxt;
      bcnt_r   <= bcnt_nxt;
      hcrc_r   <= hcrc_nxt;
      bcrc_r   <= bcrc_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // the sync byte always lands at address zero
  assign wr_en     = store && (wp_r < CNT_W'(FRAME_BYTES));
  assign wr_addr   = wp_r[ADDR_W-1:0];
  assign wr_data   = byte_in;
  assign frame_len = wp_r + CNT_W'(1);
  assign cnt       = cnt_r;

endmodule

// ===== design/esp3_frame_receiver.sv =====
// ESP3 frame receiver top: parser, frame store, readout sequencer, output register.
// Rate: one received byte per cycle while a frame is collected. A status result
// passes a holding register, then the output register, input stalled meanwhile; a
// good frame of n bytes is read from the store port one byte a cycle while out_stall
// is low, via the read and output registers, and input is stalled while it drains.
// Reset: synchronous, clears control state and parser counters; store is not cleared.
`timescale 1ns / 1ps
`include "esp3_frame_receiver_defines.svh"

module esp3_frame_receiver import esp3_fr_pkg::*; #(
  parameter int FRAME_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_carries_byte,
  output logic [7:0]  out_frame_byte,
  output logic        out_last_of_frame,
  output logic [2:0]  out_event_res,
  output logic [31:0] out_resync_total,
  output logic [31:0] out_header_error_total,
  output logic [31:0] out_data_error_total,
  output logic [31:0] out_good_frame_total
);

  localparam int CNT_W  = $clog2(FRAME_BYTES + 1);
  localparam int ADDR_W = $clog2(FRAME_BYTES);

  // input transaction
  logic              in_acc;

  // parser to store and readout
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  evt_t              evt;
  logic [CNT_W-1:0]  frame_len;
  cnt_t              cnt;

  // readout sequencer
  logic [CNT_W-1:0]  rd_left_r, rd_left_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic              rd_issue;
  logic              rd_busy;
  logic [7:0]        rd_data;

  // pending status result
  logic              stat_valid_r, stat_valid_nxt;
  evt_code_t         stat_code_r, stat_code_nxt;

  // output register
  logic              out_free;
  logic              load_byte;
  logic              load_stat;
  logic              out_valid_r, out_valid_nxt;
  logic              out_carries_r, out_carries_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  evt_code_t         out_event_r, out_event_nxt;
  cnt_t              out_cnt_r, out_cnt_nxt;

  // Hold input off while a frame drains or a status result has not yet
  // reached the output register; counters are therefore stable at load time.
  assign rd_busy  = (rd_left_r != '0) || rd_pend_r;
  assign in_stall = rd_busy || stat_valid_r;
  assign in_acc   = in_valid && !in_stall;

  esp3_fr_parser #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_acc  (in_acc),
    .byte_in   (in_rx_byte),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .evt       (evt),
    .frame_len (frame_len),
    .cnt       (cnt)
  );

  esp3_fr_store #(
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_issue),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign load_byte = rd_pend_r && out_free;
  assign load_stat = stat_valid_r && out_free;
  // issue a read only when the registered read data will have somewhere to go
  assign rd_issue  = (rd_left_r != '0) && (!rd_pend_r || load_byte);

  // readout sequencer and status holding register
  always_comb begin
    rd_left_nxt    = rd_left_r;
    rd_idx_nxt     = rd_idx_r;
    rd_pend_nxt    = rd_pend_r;
    pend_last_nxt  = pend_last_r;
    stat_valid_nxt = stat_valid_r;
    stat_code_nxt  = stat_code_r;

    priority if (evt.frame_done) begin
      rd_left_nxt = frame_len;
      rd_idx_nxt  = '0;
    end else if (rd_issue) begin
      rd_left_nxt = rd_left_r - CNT_W'(1);
      rd_idx_nxt  = rd_idx_r + ADDR_W'(1);
    end

    priority if (rd_issue) begin
      rd_pend_nxt   = 1'b1;
      pend_last_nxt = (rd_left_r == CNT_W'(1));
    end else if (load_byte) begin
      rd_pend_nxt = 1'b0;
    end

    priority if (evt.stat_valid) begin
      stat_valid_nxt = 1'b1;
      stat_code_nxt  = evt.stat_code;
    end else if (load_stat) begin
      stat_valid_nxt = 1'b0;
    end
  end

  // output register: frame bytes and status results never compete
  always_comb begin
    out_valid_nxt   = out_valid_r && out_stall;
    out_carries_nxt = out_carries_r;
    out_byte_nxt    = out_byte_r;
    out_last_nxt    = out_last_r;
    out_event_nxt   = out_event_r;
    out_cnt_nxt     = out_cnt_r;

    priority if (load_byte) begin
      out_valid_nxt   = 1'b1;
      out_carries_nxt = 1'b1;
      out_byte_nxt    = rd_data;
      out_last_nxt    = pend_last_r;
      out_event_nxt   = EV_GOOD;
      out_cnt_nxt     = cnt;
    end else if (load_stat) begin
      out_valid_nxt   = 1'b1;
      out_carries_nxt = 1'b0;
      out_byte_nxt    = '0;
      out_last_nxt    = 1'b0;
      out_event_nxt   = stat_code_r;
      out_cnt_nxt     = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_left_r    <= '0;
      rd_pend_r    <= 1'b0;
      stat_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_left_r    <= rd_left_nxt;
      rd_pend_r    <= rd_pend_nxt;
      stat_valid_r <= stat_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    pend_last_r   <= pend_last_nxt;
    stat_code_r   <= stat_code_nxt;
    out_carries_r <= out_carries_nxt;
    out_byte_r    <= out_byte_nxt;
    out_last_r    <= out_last_nxt;
    out_event_r   <= out_event_nxt;
    out_cnt_r     <= out_cnt_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_carries_byte       = out_carries_r;
  assign out_frame_byte         = out_byte_r;
  assign out_last_of_frame      = out_last_r;
  assign out_event_res          = out_event_r;
  assign out_resync_total       = out_cnt_r.resync;
  assign out_header_error_total = out_cnt_r.hdr_err;
  assign out_data_error_total   = out_cnt_r.data_err;
  assign out_good_frame_total   = out_cnt_r.good;

  `ESP3_ASSERT_IMP(a_stat_excl_read, 1'b1, !(stat_valid_r && rd_busy), "status during readout")
  `ESP3_ASSERT_IMP(a_done_when_idle, evt.frame_done, !rd_busy && !stat_valid_r, "frame overlap")
  `ESP3_ASSERT_IMP(a_last_is_good, out_valid_r && out_last_r, out_carries_r && (out_event_r == EV_GOOD), "bad last mark")
  `ESP3_ASSERT_NXT(a_last_drains, load_byte && pend_last_r, (rd_left_r == '0) && !rd_pend_r, "readout not drained")

endmodule
